// ===== src/multi_channel_heating_thermostat_defines.svh =====
// Assertion macros for the multi-channel heating thermostat.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef MULTI_CHANNEL_HEATING_THERMOSTAT_DEFINES_SVH
`define MULTI_CHANNEL_HEATING_THERMOSTAT_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define MCHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only
`define MCHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mcht_pkg.sv =====
// Shared constants, codes and types of the multi-channel heating thermostat.
// No dependencies; used by the controller, the datapath and the top level.
package mcht_pkg;

	// channel count and channel index width
	localparam int NUM_CHANNELS = 8;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// item commands
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_MEAS    = 3'd1;
	localparam logic [2:0] CMD_SETP    = 3'd2;
	localparam logic [2:0] CMD_WINDOW  = 3'd3;
	localparam logic [2:0] CMD_OUTSIDE = 3'd4;

	// register indexes (byte address / 4)
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_FREEZE  = 3'd0;
	localparam logic [2:0] REG_HYST    = 3'd1;
	localparam logic [2:0] REG_FRESH   = 3'd2;
	localparam logic [2:0] REG_BLOCK   = 3'd3;
	localparam logic [2:0] REG_DEF_MEAS = 3'd4;
	localparam logic [2:0] REG_DEF_SETP = 3'd5;

	// reset values
	localparam logic signed [15:0] RST_FREEZE   = 16'sd500;
	localparam logic [13:0]        RST_HYST     = 14'd50;
	localparam logic [15:0]        RST_FRESH    = 16'd600;
	localparam logic [15:0]        RST_BLOCK    = 16'd300;
	localparam logic signed [15:0] RST_DEF_MEAS = 16'sd2000;
	localparam logic signed [15:0] RST_DEF_SETP = 16'sd2000;

	// outside temperature above which the target is lowered
	localparam logic signed [16:0] OUTSIDE_BASE = 17'sd1000;

	// configuration seen by the datapath
	typedef struct packed {
		logic signed [15:0] frost_level;
		logic [13:0]        hysteresis;
		logic [15:0]        fresh_ticks;
		logic [15:0]        window_block_ticks;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic            upd_en;
		logic            step_en;
		logic            last;
		logic [CH_W-1:0] step_ch;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/mcht_ctrl.sv =====
// Controller of the thermostat: accepts items and sequences a tick over
// all channels, one per cycle while out_free is set. Depends on mcht_pkg.
module mcht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [2:0]          command,
	input  mcht_pkg::dp_stat_t  stat,
	output mcht_pkg::ctl_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                      state_q;
	logic [mcht_pkg::CH_W-1:0] ch_q;
	logic                      accept;
	logic                      last_ch;
	logic                      step;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign last_ch    = (ch_q == mcht_pkg::CH_W'(mcht_pkg::NUM_CHANNELS - 1));
	// a channel steps only when the output register can take its result
	assign step       = (state_q == ST_RUN) && stat.out_free;

	// commands
	always_comb begin
		cmd.upd_en  = accept && (command != mcht_pkg::CMD_TICK);
		cmd.step_en = step;
		cmd.last    = last_ch;
		cmd.step_ch = ch_q;
	end

	// state and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (command == mcht_pkg::CMD_TICK)) begin
						state_q <= ST_RUN;
						ch_q    <= '0;
					end
				end
				ST_RUN: begin
					if (step) begin
						if (last_ch) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/mcht_dp.sv =====
// Datapath of the thermostat: per-channel records, outside compensation,
// the channel step logic and the result register. Depends on mcht_pkg.
module mcht_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mcht_pkg::cfg_t      cfg,
	input  mcht_pkg::ctl_cmd_t  cmd,
	output mcht_pkg::dp_stat_t  stat,
	input  logic [2:0]          command,
	input  logic [2:0]          channel,
	input  logic signed [15:0]  value,
	input  logic                window_open,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [2:0]          out_channel,
	output logic                heating_on,
	output logic                frost_protect,
	output logic signed [15:0]  target_temp,
	output logic                reading_stale,
	output logic                last_result
);

	localparam int N = mcht_pkg::NUM_CHANNELS;

	// channel records
	logic signed [15:0] meas_q  [N];
	logic signed [15:0] setp_q  [N];
	logic               win_q   [N];
	logic               heat_q  [N];
	logic               frost_q [N];
	logic [15:0]        fresh_q [N];
	logic [15:0]        block_q [N];
	// setpoint reduction from the outside temperature
	logic [15:0]        comp_q;

	logic                      ch_ok;
	logic [mcht_pkg::CH_W-1:0] upd_ch;
	logic signed [16:0]        out_diff;
	logic [15:0]               comp_nxt;

	logic signed [15:0] rd_meas;
	logic signed [15:0] rd_setp;
	logic               rd_win;
	logic [15:0]        rd_fresh;
	logic [15:0]        rd_block;
	logic signed [15:0] tgt;
	logic signed [17:0] m18;
	logic signed [17:0] t18;
	logic signed [17:0] fz18;
	logic signed [17:0] h18;
	logic signed [17:0] t_lo;
	logic signed [17:0] t_hi;
	logic signed [17:0] fz_hi;
	logic [15:0]        fresh_nxt;
	logic [15:0]        block_nxt;
	logic               heat_nxt;
	logic               frost_nxt;

	logic result_valid_q;

	// update decode
	assign ch_ok    = (32'(channel) < N);
	assign upd_ch   = mcht_pkg::CH_W'(channel);
	assign out_diff = {value[15], value} - mcht_pkg::OUTSIDE_BASE;
	assign comp_nxt = (!out_diff[16] && (out_diff != '0)) ? {2'b00, out_diff[15:2]} : '0;

	// channel step
	always_comb begin
		rd_meas  = meas_q[cmd.step_ch];
		rd_setp  = setp_q[cmd.step_ch];
		rd_win   = win_q[cmd.step_ch];
		rd_fresh = fresh_q[cmd.step_ch];
		rd_block = block_q[cmd.step_ch];
		tgt      = rd_setp - $signed(comp_q);
		m18      = {{2{rd_meas[15]}}, rd_meas};
		t18      = {{2{tgt[15]}}, tgt};
		fz18     = {{2{cfg.frost_level[15]}}, cfg.frost_level};
		h18      = {4'b0000, cfg.hysteresis};
		t_lo     = t18 - h18;
		t_hi     = t18 + h18;
		fz_hi    = fz18 + h18;
		fresh_nxt = (rd_fresh != '0) ? rd_fresh - 16'd1 : rd_fresh;
		block_nxt = rd_block;
		heat_nxt  = heat_q[cmd.step_ch];
		frost_nxt = frost_q[cmd.step_ch];
		if (rd_block != '0) begin
			// blocking after window close
			block_nxt = rd_block - 16'd1;
			heat_nxt  = 1'b0;
			frost_nxt = 1'b0;
		end else if (rd_win) begin
			// frost protection band
			if (m18 < fz18) begin
				heat_nxt  = 1'b1;
				frost_nxt = 1'b1;
			end
			if (m18 > fz_hi) begin
				heat_nxt  = 1'b0;
				frost_nxt = 1'b0;
			end
		end else begin
			// comfort band around the target; frost flag held
			if (m18 < t_lo) begin
				heat_nxt = 1'b1;
			end
			if (m18 > t_hi) begin
				heat_nxt = 1'b0;
			end
		end
	end

	// record storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				meas_q[i]  <= mcht_pkg::RST_DEF_MEAS;
				setp_q[i]  <= mcht_pkg::RST_DEF_SETP;
				win_q[i]   <= 1'b0;
				heat_q[i]  <= 1'b0;
				frost_q[i] <= 1'b0;
				fresh_q[i] <= mcht_pkg::RST_FRESH;
				block_q[i] <= '0;
			end
			comp_q <= '0;
		end else if (cmd.upd_en) begin
			case (command)
				mcht_pkg::CMD_MEAS: begin
					if (ch_ok) begin
						meas_q[upd_ch]  <= value;
						fresh_q[upd_ch] <= cfg.fresh_ticks;
					end
				end
				mcht_pkg::CMD_SETP: begin
					if (ch_ok) begin
						setp_q[upd_ch] <= value;
					end
				end
				mcht_pkg::CMD_WINDOW: begin
					if (ch_ok) begin
						win_q[upd_ch]   <= window_open;
						block_q[upd_ch] <= window_open ? 16'd0 : cfg.window_block_ticks;
					end
				end
				mcht_pkg::CMD_OUTSIDE: comp_q <= comp_nxt;
				default: ;
			endcase
		end else if (cmd.step_en) begin
			fresh_q[cmd.step_ch] <= fresh_nxt;
			block_q[cmd.step_ch] <= block_nxt;
			heat_q[cmd.step_ch]  <= heat_nxt;
			frost_q[cmd.step_ch] <= frost_nxt;
		end
	end

	// result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.step_en) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (cmd.step_en) begin
			out_channel   <= 3'(cmd.step_ch);
			heating_on    <= heat_nxt;
			frost_protect <= frost_nxt;
			target_temp   <= tgt;
			reading_stale <= (fresh_nxt == '0);
			last_result   <= cmd.last;
		end
	end

	assign result_valid  = result_valid_q;
	assign stat.out_free = !result_valid_q || result_ready;

endmodule

// ===== src/multi_channel_heating_thermostat.sv =====
// Multi-channel heating thermostat with outside compensation and frost
// protection. Items enter on item_valid/item_ready with command, channel,
// value and window_open; update commands (measured, setpoint, window,
// outside) change state in the cycle of their transfer and give no result.
// A tick command steps channels 0..NUM_CHANNELS-1 in the single shared step
// unit, one per cycle while the result register is free, and gives one
// result transfer per channel on result_valid/result_ready, the last one
// flagged by last_result. The first result shows once the run state is
// entered and channel 0 has stepped into the result register. Updates are
// taken back to back while idle. A stalled receiver holds the result
// register and the channel sequencer waits; the next item is accepted once
// the tick's last channel has stepped, even while its result still waits.
// Configuration is an APB-style port, registers at 4 * index, pready always
// high. Reset restores registers and loads every channel from their reset
// values. Depends on mcht_pkg, mcht_ctrl, mcht_dp and the defines header.
`include "multi_channel_heating_thermostat_defines.svh"

module multi_channel_heating_thermostat (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mcht_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// items
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [2:0]                  command,
	input  logic [2:0]                  channel,
	input  logic signed [15:0]          value,
	input  logic                        window_open,
	// results
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [2:0]                  out_channel,
	output logic                        heating_on,
	output logic                        frost_protect,
	output logic signed [15:0]          target_temp,
	output logic                        reading_stale,
	output logic                        last_result
);

	logic signed [15:0] freeze_q;
	logic [13:0]        hyst_q;
	logic [15:0]        fresh_ticks_q;
	logic [15:0]        block_ticks_q;
	logic signed [15:0] def_meas_q;
	logic signed [15:0] def_setp_q;

	logic [2:0]          reg_idx;
	logic                wr_en;
	mcht_pkg::cfg_t      cfg;
	mcht_pkg::ctl_cmd_t  cmd;
	mcht_pkg::dp_stat_t  stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freeze_q      <= mcht_pkg::RST_FREEZE;
			hyst_q        <= mcht_pkg::RST_HYST;
			fresh_ticks_q <= mcht_pkg::RST_FRESH;
			block_ticks_q <= mcht_pkg::RST_BLOCK;
			def_meas_q    <= mcht_pkg::RST_DEF_MEAS;
			def_setp_q    <= mcht_pkg::RST_DEF_SETP;
		end else if (wr_en) begin
			case (reg_idx)
				mcht_pkg::REG_FREEZE:   freeze_q      <= pwdata[15:0];
				mcht_pkg::REG_HYST:     hyst_q        <= pwdata[13:0];
				mcht_pkg::REG_FRESH:    fresh_ticks_q <= pwdata[15:0];
				mcht_pkg::REG_BLOCK:    block_ticks_q <= pwdata[15:0];
				mcht_pkg::REG_DEF_MEAS: def_meas_q    <= pwdata[15:0];
				mcht_pkg::REG_DEF_SETP: def_setp_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			mcht_pkg::REG_FREEZE:   prdata = {16'h0000, freeze_q};
			mcht_pkg::REG_HYST:     prdata = {18'h00000, hyst_q};
			mcht_pkg::REG_FRESH:    prdata = {16'h0000, fresh_ticks_q};
			mcht_pkg::REG_BLOCK:    prdata = {16'h0000, block_ticks_q};
			mcht_pkg::REG_DEF_MEAS: prdata = {16'h0000, def_meas_q};
			mcht_pkg::REG_DEF_SETP: prdata = {16'h0000, def_setp_q};
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		cfg.frost_level        = freeze_q;
		cfg.hysteresis         = hyst_q;
		cfg.fresh_ticks        = fresh_ticks_q;
		cfg.window_block_ticks = block_ticks_q;
	end

	mcht_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.command    (command),
		.stat       (stat),
		.cmd        (cmd)
	);

	mcht_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.channel       (channel),
		.value         (value),
		.window_open   (window_open),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.out_channel   (out_channel),
		.heating_on    (heating_on),
		.frost_protect (frost_protect),
		.target_temp   (target_temp),
		.reading_stale (reading_stale),
		.last_result   (last_result)
	);

	// no item is taken while a tick is stepping channels
	`MCHT_ASSERT_NOW(a_no_accept_in_tick, cmd.step_en, !item_ready, "item ready during tick")
	// a tick transfer starts the sweep at channel zero
	`MCHT_ASSERT_NEXT(a_tick_start, item_valid && item_ready && (command == mcht_pkg::CMD_TICK), !item_ready && (cmd.step_ch == '0), "tick did not start at channel zero")
	// stepping the final channel frees the item channel
	`MCHT_ASSERT_NEXT(a_tick_end, cmd.step_en && cmd.last, item_ready && result_valid && last_result, "tick did not end after final channel")
	// a result is never overwritten before its transfer
	`MCHT_ASSERT_NOW(a_no_overwrite, cmd.step_en && result_valid, result_ready, "result overwritten")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the multi-channel heating thermostat: directed and random
// command traffic with random idling on both sides, checked against an in-bench predictor.
// Depends on mcht_pkg and the multi_channel_heating_thermostat top level.
module testbench;

	// unused command codes, the block must ignore them
	localparam logic [2:0] CMD_BAD_A = 3'd5;
	localparam logic [2:0] CMD_BAD_B = 3'd6;
	localparam logic [2:0] CMD_BAD_C = 3'd7;
	// outside excess over the knee is divided by this before lowering the setpoint
	localparam int COMP_DIV = 4;
	localparam int SETTLE_CYCLES = 12;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [mcht_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        item_valid;
	logic                        item_ready;
	logic [2:0]                  command;
	logic [2:0]                  channel;
	logic signed [15:0]          value;
	logic                        window_open;
	logic                        result_valid;
	logic                        result_ready;
	logic [2:0]                  out_channel;
	logic                        heating_on;
	logic                        frost_protect;
	logic signed [15:0]          target_temp;
	logic                        reading_stale;
	logic                        last_result;

	multi_channel_heating_thermostat dut (.*);

	// one channel report of a tick
	typedef struct packed {
		logic [2:0]         chan;
		logic               heat;
		logic               frost;
		logic signed [15:0] target;
		logic               stale;
		logic               last;
	} heat_report_t;

	heat_report_t reports_due[$];
	int           fail_count = 0;
	logic         steady = 1'b0;

	// predicted configuration
	logic signed [15:0] cfg_freeze;
	logic [13:0]        cfg_hyst;
	logic [15:0]        cfg_fresh;
	logic [15:0]        cfg_block;
	logic signed [15:0] cfg_def_meas;
	logic signed [15:0] cfg_def_setp;

	// predicted channel records and shared outside temperature
	logic signed [15:0] room_temp[mcht_pkg::NUM_CHANNELS];
	logic signed [15:0] setp_temp[mcht_pkg::NUM_CHANNELS];
	logic               window_mem[mcht_pkg::NUM_CHANNELS];
	logic               heat_mem[mcht_pkg::NUM_CHANNELS];
	logic               frost_mem[mcht_pkg::NUM_CHANNELS];
	logic [15:0]        fresh_left[mcht_pkg::NUM_CHANNELS];
	logic [15:0]        block_left[mcht_pkg::NUM_CHANNELS];
	logic signed [15:0] outside_now;

	always #6 clk = ~clk;

	function automatic void flag_error(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// step every channel once and queue the reports it gives
	function automatic void step_all_channels();
		int t, m, h, fz, o;
		logic signed [15:0] tgt;
		heat_report_t r;
		o = outside_now;
		h = cfg_hyst;
		fz = cfg_freeze;
		for (int c = 0; c < mcht_pkg::NUM_CHANNELS; c++) begin
			m = room_temp[c];
			if (o > mcht_pkg::OUTSIDE_BASE) begin
				t = setp_temp[c] - (o - mcht_pkg::OUTSIDE_BASE) / COMP_DIV;
				tgt = t[15:0];
			end else begin
				tgt = setp_temp[c];
			end
			t = tgt;
			if (fresh_left[c] != 16'd0) begin
				fresh_left[c]--;
			end
			if (block_left[c] != 16'd0) begin
				block_left[c]--;
				heat_mem[c] = 1'b0;
				frost_mem[c] = 1'b0;
			end else if (window_mem[c]) begin
				// frost protection around the freezing level
				if (m < fz) begin
					heat_mem[c] = 1'b1;
					frost_mem[c] = 1'b1;
				end
				if (m > fz + h) begin
					heat_mem[c] = 1'b0;
					frost_mem[c] = 1'b0;
				end
			end else begin
				// closed window: frost flag is left alone
				if (m < t - h) heat_mem[c] = 1'b1;
				if (m > t + h) heat_mem[c] = 1'b0;
			end
			r.chan = 3'(c);
			r.heat = heat_mem[c];
			r.frost = frost_mem[c];
			r.target = tgt;
			r.stale = (fresh_left[c] == 16'd0);
			r.last = (c == mcht_pkg::NUM_CHANNELS - 1);
			reports_due.push_back(r);
		end
	endfunction

	function automatic void apply_item(input logic [2:0] cmd, input logic [2:0] ch,
			input logic signed [15:0] val, input logic wo);
		case (cmd)
			mcht_pkg::CMD_TICK: step_all_channels();
			mcht_pkg::CMD_MEAS: begin
				room_temp[ch] = val;
				fresh_left[ch] = cfg_fresh;
			end
			mcht_pkg::CMD_SETP: setp_temp[ch] = val;
			mcht_pkg::CMD_WINDOW: begin
				window_mem[ch] = wo;
				block_left[ch] = wo ? 16'd0 : cfg_block;
			end
			mcht_pkg::CMD_OUTSIDE: outside_now = val;
			default: ;
		endcase
	endfunction

	// mostly near the switching points, sometimes anywhere
	function automatic logic signed [15:0] pick_temp();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 65535));
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2, 3: return 16'(int'(cfg_freeze) + int'($urandom_range(0, 600)) - 300);
			default: return 16'(1500 + int'($urandom_range(0, 1100)));
		endcase
	endfunction

	// one item transfer; entered and left at a falling edge
	task automatic send_item(input logic [2:0] cmd, input logic [2:0] ch,
			input logic signed [15:0] val, input logic wo);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		channel <= ch;
		value <= val;
		window_open <= wo;
		@(posedge clk);
		while (item_ready !== 1'b1) @(posedge clk);
		apply_item(cmd, ch, val, wo);
		@(negedge clk);
	endtask

	// let every pending report arrive, then give the block time to finish
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (reports_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_read_check(input logic [2:0] idx);
		logic [31:0] want, mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= mcht_pkg::ADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		mask = 32'hFFFF;
		case (idx)
			mcht_pkg::REG_FREEZE: want = 32'(cfg_freeze);
			mcht_pkg::REG_HYST: begin
				want = 32'(cfg_hyst);
				mask = 32'h3FFF;
			end
			mcht_pkg::REG_FRESH: want = 32'(cfg_fresh);
			mcht_pkg::REG_BLOCK: want = 32'(cfg_block);
			mcht_pkg::REG_DEF_MEAS: want = 32'(cfg_def_meas);
			default: want = 32'(cfg_def_setp);
		endcase
		if ((prdata & mask) !== (want & mask)) begin
			flag_error($sformatf("register %0d read: expected %h got %h", idx,
				want & mask, prdata & mask));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input int data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mcht_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		case (idx)
			mcht_pkg::REG_FREEZE: cfg_freeze = data[15:0];
			mcht_pkg::REG_HYST: cfg_hyst = data[13:0];
			mcht_pkg::REG_FRESH: cfg_fresh = data[15:0];
			mcht_pkg::REG_BLOCK: cfg_block = data[15:0];
			mcht_pkg::REG_DEF_MEAS: cfg_def_meas = data[15:0];
			mcht_pkg::REG_DEF_SETP: cfg_def_setp = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		reg_read_check(idx);
	endtask

	// register reset values and a tick on the reset records
	task automatic test_reset_state();
		for (int r = mcht_pkg::REG_FREEZE; r <= mcht_pkg::REG_DEF_SETP; r++) begin
			reg_read_check(3'(r));
		end
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
	endtask

	// field extremes, every command and the named corner cases
	task automatic test_directed_items();
		send_item(mcht_pkg::CMD_MEAS, 3'd0, -16'sd32768, 1'b0);
		send_item(mcht_pkg::CMD_MEAS, 3'd7, 16'sd32767, 1'b1);
		send_item(mcht_pkg::CMD_SETP, 3'd1, 16'sd32767, 1'b0);
		send_item(mcht_pkg::CMD_SETP, 3'd2, -16'sd32768, 1'b1);
		// open window and a reading below the freezing level
		send_item(mcht_pkg::CMD_WINDOW, 3'd3, 16'sd0, 1'b1);
		send_item(mcht_pkg::CMD_MEAS, 3'd3, 16'sd400, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		// hot outside pushes the lowest setpoint past the 16-bit wrap
		send_item(mcht_pkg::CMD_OUTSIDE, 3'd0, 16'sd32767, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd7, -16'sd1, 1'b1);
		// unused commands
		send_item(CMD_BAD_A, 3'd5, 16'sh5A5A, 1'b1);
		send_item(CMD_BAD_B, 3'd2, -16'sd1, 1'b0);
		send_item(CMD_BAD_C, 3'd7, 16'sd0, 1'b1);
		// just above the knee, compensation rounds to zero then one
		send_item(mcht_pkg::CMD_OUTSIDE, 3'd0, 16'sd1001, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_OUTSIDE, 3'd0, 16'sd1004, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		// cold outside: target equals setpoint
		send_item(mcht_pkg::CMD_OUTSIDE, 3'd0, -16'sd32768, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		// closing the window starts the heating block
		send_item(mcht_pkg::CMD_WINDOW, 3'd3, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
	endtask

	// register extremes; frost flag kept when the window closes without a block
	task automatic test_register_extremes();
		wait_idle();
		steady = 1'b1;
		reg_write(mcht_pkg::REG_BLOCK, 0);
		reg_write(mcht_pkg::REG_HYST, 0);
		reg_write(mcht_pkg::REG_FRESH, 0);
		send_item(mcht_pkg::CMD_WINDOW, 3'd4, 16'sd0, 1'b1);
		send_item(mcht_pkg::CMD_MEAS, 3'd4, -16'sd100, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_WINDOW, 3'd4, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);

		wait_idle();
		steady = 1'b0;
		reg_write(mcht_pkg::REG_FREEZE, -32768);
		reg_write(mcht_pkg::REG_HYST, 16383);
		reg_write(mcht_pkg::REG_FRESH, 65535);
		reg_write(mcht_pkg::REG_BLOCK, 65535);
		reg_write(mcht_pkg::REG_DEF_MEAS, -32768);
		reg_write(mcht_pkg::REG_DEF_SETP, 32767);
		send_item(mcht_pkg::CMD_WINDOW, 3'd5, 16'sd0, 1'b1);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_WINDOW, 3'd5, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_MEAS, 3'd6, 16'sd2100, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);

		wait_idle();
		reg_write(mcht_pkg::REG_FREEZE, 32767);
		reg_write(mcht_pkg::REG_HYST, 0);
		reg_write(mcht_pkg::REG_BLOCK, 1);
		reg_write(mcht_pkg::REG_DEF_MEAS, 32767);
		reg_write(mcht_pkg::REG_DEF_SETP, -32768);
		send_item(mcht_pkg::CMD_WINDOW, 3'd6, 16'sd0, 1'b1);
		send_item(mcht_pkg::CMD_MEAS, 3'd6, 16'sd32767, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_WINDOW, 3'd6, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
		send_item(mcht_pkg::CMD_TICK, 3'd0, 16'sd0, 1'b0);
	endtask

	// random settings, each followed by random command traffic
	task automatic test_random_traffic();
		logic [2:0] cmd;
		int pick;
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			reg_write(mcht_pkg::REG_FREEZE, ($urandom_range(0, 4) == 0) ?
				($urandom_range(0, 1) ? -32768 : 32767) : 200 + int'($urandom_range(0, 700)));
			reg_write(mcht_pkg::REG_HYST,
				($urandom_range(0, 5) == 0) ? 16383 : $urandom_range(0, 120));
			reg_write(mcht_pkg::REG_FRESH,
				($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 6));
			reg_write(mcht_pkg::REG_BLOCK,
				($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 4));
			reg_write(mcht_pkg::REG_DEF_MEAS, $urandom_range(0, 65535));
			reg_write(mcht_pkg::REG_DEF_SETP, $urandom_range(0, 65535));
			for (int i = 0; i < 37; i++) begin
				if (i % 16 == 0) steady = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 24) cmd = mcht_pkg::CMD_TICK;
				else if (pick < 48) cmd = mcht_pkg::CMD_MEAS;
				else if (pick < 62) cmd = mcht_pkg::CMD_SETP;
				else if (pick < 78) cmd = mcht_pkg::CMD_WINDOW;
				else if (pick < 90) cmd = mcht_pkg::CMD_OUTSIDE;
				else cmd = 3'($urandom_range(CMD_BAD_A, CMD_BAD_C));
				send_item(cmd, 3'($urandom_range(0, 7)), pick_temp(), 1'($urandom_range(0, 1)));
			end
		end
		steady = 1'b0;
	endtask

	// result receiver with a random stall before each transfer
	initial begin : result_sink
		int stall;
		result_ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (result_valid !== 1'b1) @(posedge clk);
			@(negedge clk);
		end
	end

	// compare every result transfer with the oldest pending report
	always @(posedge clk) begin : check_results
		heat_report_t got, want;
		if (arst_n && result_valid && result_ready) begin
			got = '{out_channel, heating_on, frost_protect, target_temp, reading_stale,
				last_result};
			if (reports_due.size() == 0) begin
				flag_error($sformatf("result for channel %0d with nothing pending", got.chan));
			end else begin
				want = reports_due.pop_front();
				if (got.chan !== want.chan || got.heat !== want.heat ||
						got.frost !== want.frost || got.target !== want.target ||
						got.stale !== want.stale || got.last !== want.last) begin
					flag_error($sformatf(
						"mismatch: expected ch=%0d heat=%b frost=%b target=%0d stale=%b last=%b, got ch=%0d heat=%b frost=%b target=%0d stale=%b last=%b",
						want.chan, want.heat, want.frost, want.target, want.stale, want.last,
						got.chan, got.heat, got.frost, got.target, got.stale, got.last));
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("FAIL multi_channel_heating_thermostat");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		command = mcht_pkg::CMD_TICK;
		channel = 3'd0;
		value = 16'sd0;
		window_open = 1'b0;
		// predictor state after reset
		cfg_freeze = mcht_pkg::RST_FREEZE;
		cfg_hyst = mcht_pkg::RST_HYST;
		cfg_fresh = mcht_pkg::RST_FRESH;
		cfg_block = mcht_pkg::RST_BLOCK;
		cfg_def_meas = mcht_pkg::RST_DEF_MEAS;
		cfg_def_setp = mcht_pkg::RST_DEF_SETP;
		for (int c = 0; c < mcht_pkg::NUM_CHANNELS; c++) begin
			room_temp[c] = mcht_pkg::RST_DEF_MEAS;
			setp_temp[c] = mcht_pkg::RST_DEF_SETP;
			window_mem[c] = 1'b0;
			heat_mem[c] = 1'b0;
			frost_mem[c] = 1'b0;
			fresh_left[c] = mcht_pkg::RST_FRESH;
			block_left[c] = 16'd0;
		end
		outside_now = 16'(mcht_pkg::OUTSIDE_BASE);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed_items();
		test_register_extremes();
		test_random_traffic();
		wait_idle();

		if (fail_count == 0) begin
			$display("PASS multi_channel_heating_thermostat");
		end else begin
			$display("FAIL multi_channel_heating_thermostat");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/mcht_pkg.sv
src/mcht_ctrl.sv
src/mcht_dp.sv
src/multi_channel_heating_thermostat.sv
tb/testbench.sv
